// File: rtl/core/button_debounce_event_fifo_core_defines.svh
// ----------------------------------------------------------------------------
// Button debounce event FIFO assertion macros
// Shared helpers that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_EVENT_FIFO_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_EVENT_FIFO_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDEF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BDEF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/bdef_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce event FIFO package
// Sizes, codes, shared types and helper functions of the block.
// ----------------------------------------------------------------------------
package bdef_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int SLOTS       = 2 * NUM_BUTTONS;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  localparam int OP_W       = 2;
  localparam int LEVEL_W    = 4;
  localparam int CODE_W     = 4;
  localparam int STATES_W   = 4;
  localparam int FILTER_W   = 7;
  localparam int LONG_W     = 16;
  localparam int REPEAT_W   = 8;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [FILTER_W-1:0] FILTER_RESET = 7'd5;
  localparam logic [LONG_W-1:0]   LONG_RESET   = 16'd100;
  localparam logic [REPEAT_W-1:0] REPEAT_RESET = 8'd0;
  localparam logic [CNT_W-1:0]    CNT_RESET    = CNT_W'(FILTER_RESET / 2);

  typedef enum logic [OP_W-1:0] {
    OP_SCAN  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER = 2'd0,
    CFG_LONG   = 2'd1,
    CFG_REPEAT = 2'd2
  } cfg_idx_t;

  // The encoding is the offset added to three times the button index.
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_LONG    = 2'd3
  } ev_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic [FILTER_W-1:0] debounce_ticks;
    logic [LONG_W-1:0]   long_time;
    logic [REPEAT_W-1:0] repeat_speed;
  } cfg_t;

  typedef struct packed {
    ev_kind_t first;
    ev_kind_t second;
  } lane_ev_t;

  typedef struct packed {
    logic load;
    logic pop;
    logic clear;
  } merge_ctl_t;

  typedef struct packed {
    logic busy;
    logic empty;
  } merge_stat_t;

  function automatic logic [CODE_W-1:0] event_code_of(logic [SLOT_W-1:0] slot,
                                                      ev_kind_t kind);
    int unsigned lane;
    lane = int'(slot) >> 1;
    return CODE_W'(3 * lane + int'(kind));
  endfunction

endpackage

// File: rtl/core/bdef_in_if.sv
// ----------------------------------------------------------------------------
// Button debounce event FIFO input channel
// Carries one operation and the raw button levels per transaction.
// ----------------------------------------------------------------------------
interface bdef_in_if import bdef_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [LEVEL_W-1:0]   levels;

  modport source (output valid, operation, levels, input ready);
  modport sink (input valid, operation, levels, output ready);
endinterface

// File: rtl/core/bdef_out_if.sv
// ----------------------------------------------------------------------------
// Button debounce event FIFO output channel
// Carries the popped event code and the debounced button states.
// ----------------------------------------------------------------------------
interface bdef_out_if import bdef_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   event_code;
  logic [STATES_W-1:0] pressed_states;

  modport source (output valid, event_code, pressed_states, input ready);
  modport sink (input valid, event_code, pressed_states, output ready);
endinterface

// File: rtl/core/bdef_cfg_if.sv
// ----------------------------------------------------------------------------
// Button debounce event FIFO configuration channel
// Carries one register write per transaction.
// ----------------------------------------------------------------------------
interface bdef_cfg_if import bdef_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/bdef_lane.sv
// ----------------------------------------------------------------------------
// Button debounce lane
// Debounce, long-press and repeat state of one button, updated per scan.
// ----------------------------------------------------------------------------
module bdef_lane import bdef_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     update,
  input  logic     down,
  input  cfg_t     cfg,
  input  logic     clr_repeat,
  output logic     pressed,
  output lane_ev_t ev
);

  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_next;
  logic                flag;
  logic                flag_next;
  logic [LONG_W-1:0]   long_cnt;
  logic [LONG_W-1:0]   long_cnt_next;
  logic [REPEAT_W-1:0] rep_cnt;
  logic [REPEAT_W-1:0] rep_cnt_next;
  logic [REPEAT_W-1:0] rep_inc;
  logic [CNT_W-1:0]    f_lo;
  logic [CNT_W-1:0]    f_hi;

  assign f_lo    = CNT_W'(cfg.debounce_ticks);
  assign f_hi    = {cfg.debounce_ticks, 1'b0};
  assign rep_inc = rep_cnt + REPEAT_W'(1);
  assign pressed = flag;

  always_comb begin
    cnt_next      = cnt;
    flag_next     = flag;
    long_cnt_next = long_cnt;
    rep_cnt_next  = rep_cnt;
    ev.first      = EV_NONE;
    ev.second     = EV_NONE;
    if (down) begin
      if (cnt < f_lo) begin
        cnt_next = f_lo;
      end else if (cnt < f_hi) begin
        cnt_next = cnt + CNT_W'(1);
      end else begin
        if (!flag) begin
          flag_next = 1'b1;
          ev.first  = EV_PRESS;
        end
        if (cfg.long_time != '0) begin
          if (long_cnt < cfg.long_time) begin
            long_cnt_next = long_cnt + LONG_W'(1);
            if (long_cnt_next == cfg.long_time) begin
              ev.second = EV_LONG;
            end
          end else if (cfg.repeat_speed != '0) begin
            if (rep_inc >= cfg.repeat_speed) begin
              rep_cnt_next = '0;
              ev.second    = EV_PRESS;
            end else begin
              rep_cnt_next = rep_inc;
            end
          end
        end
      end
    end else begin
      if (cnt > f_lo) begin
        cnt_next = f_lo;
      end else if (cnt != '0) begin
        cnt_next = cnt - CNT_W'(1);
      end else if (flag) begin
        flag_next = 1'b0;
        ev.first  = EV_RELEASE;
      end
      long_cnt_next = '0;
      rep_cnt_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= CNT_RESET;
      flag     <= 1'b0;
      long_cnt <= '0;
      rep_cnt  <= '0;
    end else begin
      if (update) begin
        cnt      <= cnt_next;
        flag     <= flag_next;
        long_cnt <= long_cnt_next;
        rep_cnt  <= rep_cnt_next;
      end
      if (clr_repeat) begin
        rep_cnt <= '0;
      end
    end
  end

endmodule

// File: rtl/core/bdef_merge.sv
// ----------------------------------------------------------------------------
// Button debounce event merge and FIFO
// Collects lane events and writes them into the event FIFO in order.
// ----------------------------------------------------------------------------
module bdef_merge import bdef_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  merge_ctl_t        ctl,
  input  lane_ev_t          ev [NUM_BUTTONS],
  output merge_stat_t       stat,
  output logic [CODE_W-1:0] pop_code
);

  ev_kind_t          pend [SLOTS];
  logic [CODE_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr;
  logic [SLOT_W-1:0] sel;
  logic              found;
  logic [CODE_W-1:0] wr_code;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + PTR_W'(1);
    end
    return res;
  endfunction

  // Lowest pending slot goes first: ascending button, press before long.
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (pend[k] != EV_NONE) begin
        sel   = SLOT_W'(k);
        found = 1'b1;
      end
    end
  end

  assign wr_code    = event_code_of(sel, pend[sel]);
  assign stat.busy  = found;
  assign stat.empty = (rd_ptr == wr_ptr);
  assign pop_code   = stat.empty ? '0 : mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SLOTS; k++) begin
        pend[k] <= EV_NONE;
      end
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else begin
      if (ctl.load) begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          pend[2 * i]     <= ev[i].first;
          pend[2 * i + 1] <= ev[i].second;
        end
      end else if (found) begin
        pend[sel] <= EV_NONE;
        wr_ptr    <= ptr_inc(wr_ptr);
      end
      if (ctl.pop && !stat.empty) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end else if (ctl.clear) begin
        rd_ptr <= wr_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ctl.load && found) begin
      mem[wr_ptr] <= wr_code;
    end
  end

endmodule

// File: rtl/core/button_debounce_event_fifo_core.sv
// ----------------------------------------------------------------------------
// Button debounce event FIFO core
// Debounces several buttons per scan transaction and queues their events.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                       Transfer
//  item     in   operation, levels             valid && ready
//  result   out  event_code, pressed_states    valid && ready
//  cfg      in   index, data                   valid && ready
//
// A scan passes the idle, drain and finish states; drain writes the E events it
// makes (0 to 2 x NUM_BUTTONS) through the single FIFO write port, one a cycle.
// Pop, clear and unused operations go from idle straight to the finish state.
// Reset is synchronous; no clearing pass is needed after it.
// A result waits in the output register while the next transaction is taken.
`include "button_debounce_event_fifo_core_defines.svh"

module button_debounce_event_fifo_core import bdef_pkg::*; (
  input logic      clk,
  input logic      rst,
  bdef_in_if.sink  item,
  bdef_out_if.source result,
  bdef_cfg_if.sink cfg
);

  ctl_state_t          state;
  ctl_state_t          state_next;
  cfg_t                cfg_reg;
  logic                accept;
  logic                scan_go;
  logic                pop_go;
  logic                load_out;
  logic                clr_repeat;
  logic                out_valid;
  logic [CODE_W-1:0]   out_code;
  logic [STATES_W-1:0] out_states;
  logic [CODE_W-1:0]   res_code;
  logic [CODE_W-1:0]   pop_code;
  logic [STATES_W-1:0] states_now;
  logic [NUM_BUTTONS-1:0] down;
  logic [NUM_BUTTONS-1:0] flags;
  lane_ev_t            lane_ev [NUM_BUTTONS];
  merge_ctl_t          mctl;
  merge_stat_t         mstat;

  assign cfg.ready  = 1'b1;
  assign accept     = item.valid && item.ready;
  assign clr_repeat = cfg.valid && cfg.ready &&
                      (cfg.index == CFG_LONG || cfg.index == CFG_REPEAT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.debounce_ticks <= FILTER_RESET;
      cfg_reg.long_time      <= LONG_RESET;
      cfg_reg.repeat_speed   <= REPEAT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_FILTER: cfg_reg.debounce_ticks <= cfg.data[FILTER_W-1:0];
        CFG_LONG:   cfg_reg.long_time      <= cfg.data[LONG_W-1:0];
        CFG_REPEAT: cfg_reg.repeat_speed   <= cfg.data[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (item.operation == OP_SCAN) ? ST_DRAIN : ST_FINISH;
        end
      end
      ST_DRAIN: begin
        if (!mstat.busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item.ready = 1'b0;
    load_out   = 1'b0;
    scan_go    = 1'b0;
    pop_go     = 1'b0;
    mctl       = '0;
    unique case (state)
      ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          unique case (item.operation)
            OP_SCAN: begin
              scan_go   = 1'b1;
              mctl.load = 1'b1;
            end
            OP_POP: begin
              pop_go   = 1'b1;
              mctl.pop = 1'b1;
            end
            OP_CLEAR: mctl.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_FINISH: load_out = !out_valid || result.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    if (i < LEVEL_W) begin : g_pin
      assign down[i] = item.levels[i];
    end else begin : g_nopin
      assign down[i] = 1'b0;
    end

    bdef_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .update     (scan_go),
      .down       (down[i]),
      .cfg        (cfg_reg),
      .clr_repeat (clr_repeat),
      .pressed    (flags[i]),
      .ev         (lane_ev[i])
    );
  end

  for (genvar j = 0; j < STATES_W; j++) begin : g_state
    if (j < NUM_BUTTONS) begin : g_used
      assign states_now[j] = flags[j];
    end else begin : g_unused
      assign states_now[j] = 1'b0;
    end
  end

  bdef_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mctl),
    .ev       (lane_ev),
    .stat     (mstat),
    .pop_code (pop_code)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      res_code <= pop_go ? pop_code : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_code   <= res_code;
      out_states <= states_now;
    end
  end

  assign result.valid          = out_valid;
  assign result.event_code     = out_code;
  assign result.pressed_states = out_states;

  `BDEF_ASSERT_NEXT(a_scan_drains, clk, rst, scan_go, state == ST_DRAIN)
  `BDEF_ASSERT_NOW(a_finish_settled, clk, rst, state == ST_FINISH, !mstat.busy)
  `BDEF_ASSERT_NEXT(a_empty_pop_zero, clk, rst, pop_go && mstat.empty, res_code == '0)

endmodule

// File: bench/button_debounce_event_fifo_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button debounce event FIFO core testbench
// Drives operation and level transactions through the core and checks every
// result against a built-in predictor of the debounce counters, the
// long-press and repeat timers and the circular event queue. Several register
// settings are exercised, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module button_debounce_event_fifo_core_tb;
  import bdef_pkg::*;

  localparam logic [OP_W-1:0]      OP_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG   = 2'd3;
  localparam int                   CYCLE_LIMIT  = 500000;
  localparam int                   DRAIN_CYCLES = 24;

  typedef struct packed {
    logic [CODE_W-1:0]   event_code;
    logic [STATES_W-1:0] pressed_states;
  } report_t;

  logic clk;
  logic rst;

  bdef_in_if  item_ch ();
  bdef_out_if result_ch ();
  bdef_cfg_if cfg_ch ();

  button_debounce_event_fifo_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  logic [FILTER_W-1:0] m_filter;
  logic [LONG_W-1:0]   m_long;
  logic [REPEAT_W-1:0] m_repeat;
  logic [CNT_W-1:0]    m_debounce [NUM_BUTTONS];
  logic                m_pressed  [NUM_BUTTONS];
  logic [LONG_W-1:0]   m_held     [NUM_BUTTONS];
  logic [REPEAT_W-1:0] m_rep_cnt  [NUM_BUTTONS];
  logic [CODE_W-1:0]   m_ring     [QUEUE_DEPTH];
  logic [PTR_W-1:0]    m_rd;
  logic [PTR_W-1:0]    m_wr;

  report_t            awaited_reports [$];
  report_t            want;
  logic [LEVEL_W-1:0] held_levels = '0;

  int error_count;
  int items_sent;
  int reports_checked;
  int cfg_writes;
  int presses_seen;
  int releases_seen;
  int longs_seen;
  int cycle_count;

  bit          stall_on;
  int          hold_len;
  int          hold_id;
  int          hold_seen;
  int          hold_left;
  logic [15:0] stall_pattern = 16'h6DB5;
  logic [3:0]  stall_phase = '0;

  function automatic void model_reset();
    m_filter = FILTER_RESET;
    m_long   = LONG_RESET;
    m_repeat = REPEAT_RESET;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      m_debounce[b] = CNT_RESET;
      m_pressed[b]  = 1'b0;
      m_held[b]     = '0;
      m_rep_cnt[b]  = '0;
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      m_ring[i] = '0;
    end
    m_rd = '0;
    m_wr = '0;
  endfunction

  function automatic void model_config(logic [CFG_IDX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] data);
    case (idx) inside
      CFG_FILTER: m_filter = data[FILTER_W-1:0];
      CFG_LONG, CFG_REPEAT: begin
        if (idx == CFG_LONG) begin
          m_long = data[LONG_W-1:0];
        end else begin
          m_repeat = data[REPEAT_W-1:0];
        end
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          m_rep_cnt[b] = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_event(int b, ev_kind_t kind);
    m_ring[m_wr] = CODE_W'(3 * b + int'(kind));
    m_wr = m_wr + PTR_W'(1);
  endfunction

  function automatic void scan_button(int b, bit down);
    int cnt;
    int f;
    cnt = int'(m_debounce[b]);
    f   = int'(m_filter);
    if (down) begin
      if (cnt < f) begin
        m_debounce[b] = CNT_W'(f);
      end else if (cnt < 2 * f) begin
        m_debounce[b] = CNT_W'(cnt + 1);
      end else begin
        if (!m_pressed[b]) begin
          m_pressed[b] = 1'b1;
          queue_event(b, EV_PRESS);
        end
        if (m_long != 0) begin
          if (m_held[b] < m_long) begin
            m_held[b] = m_held[b] + LONG_W'(1);
            if (m_held[b] == m_long) begin
              queue_event(b, EV_LONG);
            end
          end else if (m_repeat != 0) begin
            m_rep_cnt[b] = m_rep_cnt[b] + REPEAT_W'(1);
            if (m_rep_cnt[b] >= m_repeat) begin
              m_rep_cnt[b] = '0;
              queue_event(b, EV_PRESS);
            end
          end
        end
      end
    end else begin
      if (cnt > f) begin
        m_debounce[b] = CNT_W'(f);
      end else if (cnt != 0) begin
        m_debounce[b] = CNT_W'(cnt - 1);
      end else if (m_pressed[b]) begin
        m_pressed[b] = 1'b0;
        queue_event(b, EV_RELEASE);
      end
      m_held[b]    = '0;
      m_rep_cnt[b] = '0;
    end
  endfunction

  function automatic report_t predict_report(logic [OP_W-1:0] op,
                                             logic [LEVEL_W-1:0] lv);
    report_t r;
    r = '0;
    case (op)
      OP_SCAN: begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          scan_button(b, lv[b]);
        end
      end
      OP_POP: begin
        if (m_rd != m_wr) begin
          r.event_code = m_ring[m_rd];
          m_rd = m_rd + PTR_W'(1);
        end
      end
      OP_CLEAR: m_rd = m_wr;
      default: ;
    endcase
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      r.pressed_states[b] = m_pressed[b];
    end
    return r;
  endfunction

  function automatic logic [OP_W-1:0] random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 68) return OP_SCAN;
    if (r < 92) return OP_POP;
    if (r < 96) return OP_CLEAR;
    return OP_UNUSED;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [LEVEL_W-1:0] lv);
    item_ch.valid     <= 1'b1;
    item_ch.operation <= op;
    item_ch.levels    <= lv;
    do @(posedge clk); while (!item_ch.ready);
    awaited_reports.push_back(predict_report(op, lv));
    items_sent++;
  endtask

  task automatic item_gap(input int n);
    if (n > 0) begin
      item_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_reports.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    model_config(idx, data);
    cfg_writes++;
  endtask

  task automatic apply_settings(input int unsigned f, input int unsigned l,
                                input int unsigned r);
    write_reg(CFG_FILTER,
              CFG_DATA_W'(f) | (CFG_DATA_W'($urandom_range(0, 511)) << FILTER_W));
    write_reg(CFG_LONG, CFG_DATA_W'(l));
    write_reg(CFG_REPEAT,
              CFG_DATA_W'(r) | (CFG_DATA_W'($urandom_range(0, 255)) << REPEAT_W));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_traffic(input int n, input int toggle_div, input bit gappy);
    logic [LEVEL_W-1:0] lv;
    int                 burst_left;
    burst_left = 0;
    for (int k = 0; k < n; k++) begin
      if (gappy) begin
        if (burst_left == 0) begin
          item_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
      end
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        if ($urandom_range(1, toggle_div) == 1) held_levels[b] = ~held_levels[b];
      end
      lv = held_levels;
      if ($urandom_range(0, 9) == 0) lv[$urandom_range(0, NUM_BUTTONS - 1)] ^= 1'b1;
      if ($urandom_range(0, 19) == 0) lv = LEVEL_W'($urandom_range(0, 15));
      send_item(random_op(), lv);
    end
  endtask

  task automatic test_basic_ops();
    repeat (7) send_item(OP_SCAN, 4'hF);
    send_item(OP_POP, 4'h0);
    send_item(OP_POP, 4'hF);
    send_item(OP_UNUSED, 4'hF);
    send_item(OP_CLEAR, 4'h0);
    send_item(OP_POP, 4'h0);
    repeat (7) send_item(OP_SCAN, 4'h0);
    repeat (5) send_item(OP_POP, 4'h0);
    wait_drained();
  endtask

  task automatic test_filter_zero();
    write_reg(CFG_NO_REG, 16'hFFFF);
    write_reg(CFG_FILTER, 16'hFF80);
    cfg_ch.valid <= 1'b0;
    send_item(OP_SCAN, 4'hA);
    send_item(OP_SCAN, 4'h5);
    send_item(OP_SCAN, 4'h0);
    repeat (3) send_item(OP_POP, 4'h0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    stall_on = 1'b0;
    hold_len = 300;
    hold_id++;
    for (int k = 0; k < 48; k++) begin
      send_item(random_op(), LEVEL_W'($urandom_range(0, 15)));
    end
    wait_drained();
  endtask

  task automatic test_random_phases();
    int unsigned filt_set   [8] = '{1, 2, 127, 3, 0, 1, 4, 2};
    int unsigned long_set   [8] = '{1, 4, 300, 12, 2, 0, 6, 65535};
    int unsigned rep_set    [8] = '{1, 3, 0, 0, 1, 5, 255, 2};
    int          count_set  [8] = '{220, 220, 150, 220, 200, 220, 220, 200};
    int          toggle_set [8] = '{12, 16, 300, 20, 6, 12, 18, 14};
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      apply_settings(filt_set[p], long_set[p], rep_set[p]);
      stall_on = (p % 2 == 1);
      random_traffic(count_set[p], toggle_set[p], p % 3 != 2);
    end
    stall_on = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_id != hold_seen) begin
      hold_seen = hold_id;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_ch.ready <= 1'b0;
    end else if (!stall_on) begin
      result_ch.ready <= 1'b1;
    end else begin
      result_ch.ready <= stall_pattern[stall_phase];
      stall_phase = stall_phase + 4'd1;
      if (stall_phase == 0 && $urandom_range(0, 2) == 0) begin
        stall_pattern = 16'($urandom) | 16'h1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (awaited_reports.size() == 0) begin
        $error("Unexpected result: event_code %0d pressed_states %b",
               result_ch.event_code, result_ch.pressed_states);
        error_count++;
      end else begin
        want = awaited_reports.pop_front();
        reports_checked++;
        if (result_ch.event_code !== want.event_code) begin
          $error("event_code: expected %0d, actual %0d", want.event_code,
                 result_ch.event_code);
          error_count++;
        end
        if (result_ch.pressed_states !== want.pressed_states) begin
          $error("pressed_states: expected %b, actual %b", want.pressed_states,
                 result_ch.pressed_states);
          error_count++;
        end
        if (want.event_code != 0) begin
          case ((int'(want.event_code) - 1) % 3)
            0:       presses_seen++;
            1:       releases_seen++;
            default: longs_seen++;
          endcase
        end
      end
    end
  end

  initial begin
    rst               <= 1'b1;
    item_ch.valid     <= 1'b0;
    item_ch.operation <= OP_SCAN;
    item_ch.levels    <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_FILTER;
    cfg_ch.data       <= '0;
    model_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_filter_zero();
    test_backpressure();
    test_random_phases();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_reports.size() != 0) begin
      $error("%0d results never arrived", awaited_reports.size());
      error_count++;
    end
    $display("Sent %0d transactions, checked %0d results, made %0d register writes.",
             items_sent, reports_checked, cfg_writes);
    $display("Popped events: %0d press, %0d release, %0d long-press.",
             presses_seen, releases_seen, longs_seen);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
